@@ sv/ctc_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar time counter package
// Shared types, codes, constants and calendar helper functions.
// ----------------------------------------------------------------------------
package ctc_pkg;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ADD  = 2'd1,
        OP_FIT  = 2'd2,
        OP_CMP  = 2'd3
    } t_opcode;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_ADD  = 2'd2,
        S_DONE = 2'd3
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic fit;
        logic cmp;
        logic add_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_opcode op;
        logic    add_last;
    } t_dp_stat;

    // Compare result codes.
    localparam logic [1:0] ORD_EARLIER = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_LATER   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_FIRST_HOUR = 1'b0;
    localparam logic CFG_LAST_HOUR  = 1'b1;

    // Calendar constants.
    localparam logic [4:0]  HOUR_MAX     = 5'd23;
    localparam logic [5:0]  MINUTE_MAX   = 6'd59;
    localparam logic [19:0] MIN_PER_HOUR = 20'd60;
    localparam logic [19:0] MIN_PER_DAY  = 20'd1440;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_MAR    = 4'd3;
    localparam logic [3:0]  MONTH_APR    = 4'd4;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [4:0]  DAY_LAST_MAR = 5'd31;
    localparam logic [4:0]  DAY_AFTER_JUMP = 5'd14;
    localparam logic [15:0] JUMP_YEAR    = 16'd1916;
    localparam logic [15:0] RESET_YEAR   = 16'd1970;

    // True when the year is a multiple of 25. The year is folded with
    // 256 = 6, 64 = 14 and 32 = 7 (mod 25) until it is below 125.
    function automatic logic f_div25(input logic [15:0] year);
        logic [10:0] s1;
        logic [8:0]  s2;
        logic [6:0]  s3;
        s1 = 11'(year[15:8]) * 11'd6 + 11'(year[7:0]);
        s2 = 9'(s1[10:6]) * 9'd14 + 9'(s1[5:0]);
        s3 = 7'(s2[8:5]) * 7'd7 + 7'(s2[4:0]);
        return s3 inside {7'd0, 7'd25, 7'd50, 7'd75, 7'd100};
    endfunction

    // Gregorian leap year rule.
    function automatic logic f_is_leap(input logic [15:0] year);
        logic z25;
        z25 = f_div25(year);
        return ((year[1:0] == 2'd0) && !z25) || ((year[3:0] == 4'd0) && z25);
    endfunction

    // Length of a month in days (month in 1..12).
    function automatic logic [4:0] f_month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            MONTH_FEB:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:        len = 5'd30;
            default:                        len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ sv/calendar_time_counter.sv @@
// ----------------------------------------------------------------------------
// Calendar time counter
// Minute to year calendar with load, add minutes, hour-window fit and compare.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Payload
//  ---------+--------------------+------------------------------------------
//  item in  | start, busy        | i_opcode, i_minutes_to_add, i_*_in
//  result   | o_done (1 cycle)   | o_*_now, o_order_result, o_load_rejected
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// An item is taken when start is high and busy is low. For load, fit and
// compare the controller passes from its execute state to its done state,
// where o_done is raised. An add steps through the whole days, then the whole
// leftover hours, then the leftover minutes of the minute count, one calendar
// step per cycle through the shared day/hour advance logic, then reports.
// Reset is synchronous and restores 1 January 1970, 00:00 and the full window.
// The result strobe is high for one cycle only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module calendar_time_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [19:0] i_minutes_to_add,
    input  logic [7:0]  i_hour_in,
    input  logic [7:0]  i_minute_in,
    input  logic [7:0]  i_day_in,
    input  logic [7:0]  i_month_in,
    input  logic [15:0] i_year_in,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    output logic        o_done,
    output logic [5:0]  o_minute_now,
    output logic [4:0]  o_hour_now,
    output logic [4:0]  o_day_now,
    output logic [3:0]  o_month_now,
    output logic [15:0] o_year_now,
    output logic [1:0]  o_order_result,
    output logic        o_load_rejected
);

    ctc_pkg::t_dp_cmd  dp_cmd;
    ctc_pkg::t_dp_stat dp_stat;

    // Sequencer.
    ctc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Calendar registers and step logic.
    ctc_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_minutes_to_add (i_minutes_to_add),
        .i_hour_in        (i_hour_in),
        .i_minute_in      (i_minute_in),
        .i_day_in         (i_day_in),
        .i_month_in       (i_month_in),
        .i_year_in        (i_year_in),
        .o_minute_now     (o_minute_now),
        .o_hour_now       (o_hour_now),
        .o_day_now        (o_day_now),
        .o_month_now      (o_month_now),
        .o_year_now       (o_year_now),
        .o_order_result   (o_order_result),
        .o_load_rejected  (o_load_rejected)
    );

endmodule

@@ sv/ctc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Calendar time counter controller
// Sequences one item at a time: capture, execute or step the add loop, report.
// ----------------------------------------------------------------------------
module ctc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ctc_pkg::t_dp_stat i_stat,
    output ctc_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    ctc_pkg::t_ctrl_state r_state;
    ctc_pkg::t_ctrl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            ctc_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ctc_pkg::S_EXEC;
                end
            end
            ctc_pkg::S_EXEC: begin
                n_state = ctc_pkg::S_DONE;
                case (i_stat.op)
                    ctc_pkg::OP_LOAD: o_cmd.load = 1'b1;
                    ctc_pkg::OP_FIT:  o_cmd.fit  = 1'b1;
                    ctc_pkg::OP_CMP:  o_cmd.cmp  = 1'b1;
                    ctc_pkg::OP_ADD: begin
                        o_cmd.add_step = 1'b1;
                        if (!i_stat.add_last) begin
                            n_state = ctc_pkg::S_ADD;
                        end
                    end
                    default: n_state = ctc_pkg::S_DONE;
                endcase
            end
            ctc_pkg::S_ADD: begin
                o_cmd.add_step = 1'b1;
                if (i_stat.add_last) begin
                    n_state = ctc_pkg::S_DONE;
                end
            end
            ctc_pkg::S_DONE: begin
                o_done  = 1'b1;
                n_state = ctc_pkg::S_IDLE;
            end
            default: n_state = ctc_pkg::S_IDLE;
        endcase
    end

endmodule

@@ sv/ctc_dpath.sv @@
// ----------------------------------------------------------------------------
// Calendar time counter datapath
// Time registers, window registers, input capture and the calendar step logic.
// ----------------------------------------------------------------------------
module ctc_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctc_pkg::t_dp_cmd  i_cmd,
    output ctc_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [4:0]        i_cfg_data,
    input  logic [1:0]        i_opcode,
    input  logic [19:0]       i_minutes_to_add,
    input  logic [7:0]        i_hour_in,
    input  logic [7:0]        i_minute_in,
    input  logic [7:0]        i_day_in,
    input  logic [7:0]        i_month_in,
    input  logic [15:0]       i_year_in,
    output logic [5:0]        o_minute_now,
    output logic [4:0]        o_hour_now,
    output logic [4:0]        o_day_now,
    output logic [3:0]        o_month_now,
    output logic [15:0]       o_year_now,
    output logic [1:0]        o_order_result,
    output logic              o_load_rejected
);

    // Stored time and window.
    logic [5:0]  r_minute, n_minute;
    logic [4:0]  r_hour,   n_hour;
    logic [4:0]  r_day,    n_day;
    logic [3:0]  r_month,  n_month;
    logic [15:0] r_year,   n_year;
    logic [4:0]  r_first_hour;
    logic [4:0]  r_last_hour;
    logic [1:0]  r_order,  n_order;
    logic        r_rejected, n_rejected;

    // Captured item.
    ctc_pkg::t_opcode r_op;
    logic [19:0] r_rem, n_rem;
    logic [7:0]  r_in_hour;
    logic [7:0]  r_in_minute;
    logic [7:0]  r_in_day;
    logic [7:0]  r_in_month;
    logic [15:0] r_in_year;

    // Day and hour advance of the stored time.
    logic [4:0]  adv_day;
    logic [3:0]  adv_month;
    logic [15:0] adv_year;
    logic [4:0]  cur_len;
    logic        hour_wrap;

    // Load check, compare and add helpers.
    logic [4:0]  in_len;
    logic        load_ok;
    logic [47:0] cmp_stored;
    logic [47:0] cmp_input;
    logic [4:0]  fit_hour;
    logic [6:0]  min_sum;

    // Window registers; values above the last hour of a day are clamped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_hour <= 5'd0;
            r_last_hour  <= ctc_pkg::HOUR_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ctc_pkg::CFG_FIRST_HOUR: r_first_hour <= (i_cfg_data > ctc_pkg::HOUR_MAX) ?
                                                         ctc_pkg::HOUR_MAX : i_cfg_data;
                ctc_pkg::CFG_LAST_HOUR:  r_last_hour  <= (i_cfg_data > ctc_pkg::HOUR_MAX) ?
                                                         ctc_pkg::HOUR_MAX : i_cfg_data;
                default: r_last_hour <= r_last_hour;
            endcase
        end
    end

    // Item capture registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= ctc_pkg::OP_LOAD;
        end else if (i_cmd.capture) begin
            r_op <= ctc_pkg::t_opcode'(i_opcode);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_hour   <= i_hour_in;
            r_in_minute <= i_minute_in;
            r_in_day    <= i_day_in;
            r_in_month  <= i_month_in;
            r_in_year   <= i_year_in;
        end
    end

    // Next day, with the fixed jump from 31 March to 14 April 1916.
    always_comb begin
        cur_len   = ctc_pkg::f_month_len(r_month, ctc_pkg::f_is_leap(r_year));
        adv_day   = r_day + 5'd1;
        adv_month = r_month;
        adv_year  = r_year;
        if (r_day == ctc_pkg::DAY_LAST_MAR && r_month == ctc_pkg::MONTH_MAR &&
            r_year == ctc_pkg::JUMP_YEAR) begin
            adv_day   = ctc_pkg::DAY_AFTER_JUMP;
            adv_month = ctc_pkg::MONTH_APR;
        end else if (r_day >= cur_len) begin
            adv_day = 5'd1;
            if (r_month >= ctc_pkg::MONTH_DEC) begin
                adv_month = 4'd1;
                adv_year  = r_year + 16'd1;
            end else begin
                adv_month = r_month + 4'd1;
            end
        end
    end

    assign hour_wrap = (r_hour >= ctc_pkg::HOUR_MAX);

    // Load validation of the captured time.
    always_comb begin
        in_len  = ctc_pkg::f_month_len(r_in_month[3:0], ctc_pkg::f_is_leap(r_in_year));
        load_ok = (r_in_hour <= 8'(ctc_pkg::HOUR_MAX)) &&
                  (r_in_minute <= 8'(ctc_pkg::MINUTE_MAX)) &&
                  (r_in_month >= 8'd1) && (r_in_month <= 8'(ctc_pkg::MONTH_DEC)) &&
                  (r_in_day >= 8'd1) && (r_in_day <= 8'(in_len));
    end

    // Lexicographic compare as one wide number, year first.
    assign cmp_stored = {r_year, 4'd0, r_month, 3'd0, r_day, 3'd0, r_hour, 2'd0, r_minute};
    assign cmp_input  = {r_in_year, r_in_month, r_in_day, r_in_hour, r_in_minute};

    assign fit_hour = (r_hour < r_first_hour) ? r_first_hour : r_hour;
    assign min_sum  = 7'(r_minute) + 7'(r_rem[5:0]);

    // The add loop takes whole days, then whole hours, then the leftover minutes.
    assign o_stat.op       = r_op;
    assign o_stat.add_last = (r_rem < ctc_pkg::MIN_PER_HOUR);

    // Next values of the time and result registers.
    always_comb begin
        n_minute   = r_minute;
        n_hour     = r_hour;
        n_day      = r_day;
        n_month    = r_month;
        n_year     = r_year;
        n_rem      = r_rem;
        n_order    = r_order;
        n_rejected = r_rejected;
        if (i_cmd.capture) begin
            n_rem      = i_minutes_to_add;
            n_order    = ctc_pkg::ORD_EARLIER;
            n_rejected = 1'b0;
        end
        if (i_cmd.load) begin
            if (load_ok) begin
                n_minute = r_in_minute[5:0];
                n_hour   = r_in_hour[4:0];
                n_day    = r_in_day[4:0];
                n_month  = r_in_month[3:0];
                n_year   = r_in_year;
            end else begin
                n_rejected = 1'b1;
            end
        end
        if (i_cmd.cmp) begin
            if (cmp_stored < cmp_input) begin
                n_order = ctc_pkg::ORD_EARLIER;
            end else if (cmp_stored > cmp_input) begin
                n_order = ctc_pkg::ORD_LATER;
            end else begin
                n_order = ctc_pkg::ORD_EQUAL;
            end
        end
        if (i_cmd.fit) begin
            if (fit_hour > r_last_hour) begin
                n_day    = adv_day;
                n_month  = adv_month;
                n_year   = adv_year;
                n_hour   = r_first_hour;
                n_minute = 6'd0;
            end else if (r_hour < r_first_hour) begin
                n_hour   = r_first_hour;
                n_minute = 6'd0;
            end
        end
        if (i_cmd.add_step) begin
            if (r_rem >= ctc_pkg::MIN_PER_DAY) begin
                n_rem   = r_rem - ctc_pkg::MIN_PER_DAY;
                n_day   = adv_day;
                n_month = adv_month;
                n_year  = adv_year;
            end else begin
                if (r_rem >= ctc_pkg::MIN_PER_HOUR) begin
                    n_rem = r_rem - ctc_pkg::MIN_PER_HOUR;
                end else begin
                    n_rem = 20'd0;
                    if (min_sum > 7'(ctc_pkg::MINUTE_MAX)) begin
                        n_minute = 6'(min_sum - 7'd60);
                    end else begin
                        n_minute = min_sum[5:0];
                    end
                end
                // One hour step, either whole or from a minute carry.
                if (r_rem >= ctc_pkg::MIN_PER_HOUR || min_sum > 7'(ctc_pkg::MINUTE_MAX)) begin
                    if (hour_wrap) begin
                        n_hour  = 5'd0;
                        n_day   = adv_day;
                        n_month = adv_month;
                        n_year  = adv_year;
                    end else begin
                        n_hour = r_hour + 5'd1;
                    end
                end
            end
        end
    end

    // Time and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute   <= 6'd0;
            r_hour     <= 5'd0;
            r_day      <= 5'd1;
            r_month    <= 4'd1;
            r_year     <= ctc_pkg::RESET_YEAR;
            r_order    <= ctc_pkg::ORD_EARLIER;
            r_rejected <= 1'b0;
        end else begin
            r_minute   <= n_minute;
            r_hour     <= n_hour;
            r_day      <= n_day;
            r_month    <= n_month;
            r_year     <= n_year;
            r_order    <= n_order;
            r_rejected <= n_rejected;
        end
    end

    // Remaining minutes of an add.
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
    end

    assign o_minute_now    = r_minute;
    assign o_hour_now      = r_hour;
    assign o_day_now       = r_day;
    assign o_month_now     = r_month;
    assign o_year_now      = r_year;
    assign o_order_result  = r_order;
    assign o_load_rejected = r_rejected;

endmodule

@@ sv/ctc_checker.sv @@
// ----------------------------------------------------------------------------
// Calendar time counter checker
// Port-level properties of the item and result handshake and the result data.
// ----------------------------------------------------------------------------
module ctc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [5:0]  o_minute_now,
    input logic [4:0]  o_hour_now,
    input logic [1:0]  o_order_result
);

    // A result only appears while an item is in progress.
    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe without an item in progress");

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // A result strobe does not repeat straight away, and the block is then free again.
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe longer than one cycle");

    // At each result, the reported hour, minute and compare code are in their ranges.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_hour_now <= 5'd23 && o_minute_now <= 6'd59 &&
                    o_order_result != 2'd3))
        else $error("result field out of range");

endmodule

bind calendar_time_counter ctc_checker u_ctc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_minute_now   (o_minute_now),
    .o_hour_now     (o_hour_now),
    .o_order_result (o_order_result)
);
